// ===== rtl/received_line_lifo_stack_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the received line LIFO stack core
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RECEIVED_LINE_LIFO_STACK_CORE_MACROS_SVH
`define RECEIVED_LINE_LIFO_STACK_CORE_MACROS_SVH

// same-cycle implication
`define LLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lls_pkg.sv =====
// ----------------------------------------------------------------------------
// lls_pkg
// Shared constants, types and command/status structs of the line stack core.
// ----------------------------------------------------------------------------
package lls_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int LINE_CHARS  = 20;
    localparam int STORE_DEPTH = STACK_DEPTH * LINE_CHARS;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int POS_W  = $clog2(LINE_CHARS);

    localparam logic [7:0] LINE_TERM_RESET = 8'd13;

    // result status codes
    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_COMMIT = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_LONG   = 3'd3;
    localparam logic [2:0] ST_CHAR   = 3'd4;
    localparam logic [2:0] ST_EMPTY  = 3'd5;

    // request function codes
    localparam logic FUNC_RX  = 1'b0;
    localparam logic FUNC_POP = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [3:0]        t_lines;

    typedef struct packed {
        logic byte_op;   // handle a received byte
        logic pop_op;    // start a pop
        logic pop_char;  // emit current character, fetch next
        logic pop_end;   // emit closing zero
    } t_dp_cmd;

    typedef struct packed {
        logic stack_empty;
        logic idx_done;
        logic char_zero;
    } t_dp_stat;

endpackage

// ===== rtl/received_line_lifo_stack_core.sv =====
// ----------------------------------------------------------------------------
// received_line_lifo_stack_core
// Stack of fixed-length text lines built from received bytes, popped per char.
// ----------------------------------------------------------------------------
// A received-byte request leaves o_busy low, and its single result strobes on
// the next cycle; a pop of an empty stack answers the same way. A pop of a
// line returning k characters (k at most LINE_CHARS-1, bounded by
// i_max_length-1 and the stored zero) holds o_busy high and strobes k+1
// results, one per cycle, the last being a zero with o_last set; the pace is
// one read a cycle from the single-read-port line store.
// Results must be taken when o_strobe is high; there is no back-pressure.
module received_line_lifo_stack_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic       i_func,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_max_length,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_strobe,
    output logic [2:0] o_status,
    output logic [7:0] o_out_char,
    output logic       o_last,
    output logic [3:0] o_lines_held
);

    lls_pkg::t_dp_cmd  cmd;
    lls_pkg::t_dp_stat stat;

    lls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    lls_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rx_byte    (i_rx_byte),
        .i_max_length (i_max_length),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_stat       (stat),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_out_char   (o_out_char),
        .o_last       (o_last),
        .o_lines_held (o_lines_held)
    );

endmodule

// ===== rtl/lls_ctrl.sv =====
// ----------------------------------------------------------------------------
// lls_ctrl
// Controller: accepts requests and sequences the character walk of a pop.
// ----------------------------------------------------------------------------
module lls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_func,
    input  lls_pkg::t_dp_stat i_stat,
    output logic              o_busy,
    output lls_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_func == lls_pkg::FUNC_POP) begin
                        o_cmd.pop_op = 1'b1;
                        if (!i_stat.stack_empty) begin
                            n_state = S_POP;
                        end
                    end else begin
                        o_cmd.byte_op = 1'b1;
                    end
                end
            end
            S_POP: begin
                if (i_stat.idx_done || i_stat.char_zero) begin
                    o_cmd.pop_end = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.pop_char = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state == S_POP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== rtl/lls_dpath.sv =====
// ----------------------------------------------------------------------------
// lls_dpath
// Datapath: line store, line count, write position, pop walk and result regs.
// ----------------------------------------------------------------------------
`include "received_line_lifo_stack_core_macros.svh"

module lls_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lls_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_max_length,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    output lls_pkg::t_dp_stat o_stat,
    output logic              o_strobe,
    output logic [2:0]        o_status,
    output logic [7:0]        o_out_char,
    output logic              o_last,
    output logic [3:0]        o_lines_held
);

    logic [7:0] mem [lls_pkg::STORE_DEPTH];

    logic [7:0]     r_term;
    lls_pkg::t_cnt  r_count, n_count;
    lls_pkg::t_pos  r_pos, n_pos;
    lls_pkg::t_pos  r_idx, n_idx;
    lls_pkg::t_pos  r_limit, n_limit;
    lls_pkg::t_addr r_base, n_base;
    logic [7:0]     r_rd_data;

    logic             r_strobe, n_strobe;
    logic [2:0]       r_status, n_status;
    logic [7:0]       r_out_char, n_out_char;
    logic             r_last, n_last;
    lls_pkg::t_lines  r_lines, n_lines;

    logic           wr_en;
    logic [7:0]     wr_data;
    lls_pkg::t_addr wr_addr;
    logic           rd_en;
    lls_pkg::t_addr rd_addr;

    logic       is_full;
    logic       is_term;
    logic       is_long;
    logic [7:0] ml_m1;

    assign is_full = (r_count >= lls_pkg::t_cnt'(lls_pkg::STACK_DEPTH));
    assign is_term = (i_rx_byte == r_term);
    assign is_long = (r_pos >= lls_pkg::t_pos'(lls_pkg::LINE_CHARS - 1));
    assign ml_m1   = (i_max_length == 8'd0) ? 8'd0 : i_max_length - 8'd1;

    assign wr_addr = lls_pkg::t_addr'(r_count) * lls_pkg::t_addr'(lls_pkg::LINE_CHARS)
                   + lls_pkg::t_addr'(r_pos);

    always_comb begin
        n_count    = r_count;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_limit    = r_limit;
        n_base     = r_base;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_out_char = 8'd0;
        n_last     = 1'b1;
        wr_en      = 1'b0;
        wr_data    = i_rx_byte;
        rd_en      = 1'b0;
        rd_addr    = r_base + lls_pkg::t_addr'(r_idx) + lls_pkg::t_addr'(1);

        if (i_cmd.byte_op) begin
            n_strobe = 1'b1;
            if (is_full) begin
                n_status = lls_pkg::ST_FULL;
            end else if (is_term) begin
                wr_en    = 1'b1;
                wr_data  = 8'd0;
                n_count  = r_count + lls_pkg::t_cnt'(1);
                n_pos    = '0;
                n_status = lls_pkg::ST_COMMIT;
            end else if (is_long) begin
                n_status = lls_pkg::ST_LONG;
            end else begin
                wr_en    = 1'b1;
                n_pos    = r_pos + lls_pkg::t_pos'(1);
                n_status = lls_pkg::ST_STORED;
            end
        end

        if (i_cmd.pop_op) begin
            // any pending partial line is thrown away
            n_pos = '0;
            if (r_count == '0) begin
                n_strobe = 1'b1;
                n_status = lls_pkg::ST_EMPTY;
            end else begin
                n_count = r_count - lls_pkg::t_cnt'(1);
                n_base  = lls_pkg::t_addr'(n_count) * lls_pkg::t_addr'(lls_pkg::LINE_CHARS);
                n_idx   = '0;
                n_limit = (ml_m1 > 8'(lls_pkg::LINE_CHARS - 1))
                        ? lls_pkg::t_pos'(lls_pkg::LINE_CHARS - 1)
                        : lls_pkg::t_pos'(ml_m1);
                rd_en   = 1'b1;
                rd_addr = n_base;
            end
        end

        if (i_cmd.pop_char) begin
            // read of idx+1 overlaps the emit of idx
            rd_en      = 1'b1;
            n_idx      = r_idx + lls_pkg::t_pos'(1);
            n_strobe   = 1'b1;
            n_status   = lls_pkg::ST_CHAR;
            n_out_char = r_rd_data;
            n_last     = 1'b0;
        end

        if (i_cmd.pop_end) begin
            n_strobe = 1'b1;
            n_status = lls_pkg::ST_CHAR;
        end

        n_lines = lls_pkg::t_lines'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term   <= lls_pkg::LINE_TERM_RESET;
            r_count  <= '0;
            r_pos    <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_term <= i_cfg_wdata;
            end
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_limit    <= n_limit;
        r_base     <= n_base;
        r_status   <= n_status;
        r_out_char <= n_out_char;
        r_last     <= n_last;
        r_lines    <= n_lines;
    end

    assign o_stat.stack_empty = (r_count == '0);
    assign o_stat.idx_done    = (r_idx >= r_limit);
    assign o_stat.char_zero   = (r_rd_data == 8'd0);

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_out_char   = r_out_char;
    assign o_last       = r_last;
    assign o_lines_held = r_lines;

    `LLS_ASSERT_NOW(a_count_range, 1'b1, r_count <= lls_pkg::t_cnt'(lls_pkg::STACK_DEPTH), "line count above stack depth")
    `LLS_ASSERT_NOW(a_pos_range, 1'b1, r_pos <= lls_pkg::t_pos'(lls_pkg::LINE_CHARS - 1), "write position past slot")
    `LLS_ASSERT_NOW(a_char_in_limit, i_cmd.pop_char, r_idx < r_limit, "pop char beyond limit")
    `LLS_ASSERT_NEXT(a_end_is_last, i_cmd.pop_end, r_strobe && r_last && (r_out_char == 8'd0), "pop end not a last zero result")

endmodule
